[rtl/core/gif_block_stream_parser_defines.svh]
// ----------------------------------------------------------------------------
// GIF block stream parser assertion macros
// Shared concurrent assertion forms for the parser RTL.
// ----------------------------------------------------------------------------
`ifndef GIF_BLOCK_STREAM_PARSER_DEFINES_SVH
`define GIF_BLOCK_STREAM_PARSER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GBSP_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GBSP_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/gbsp_pkg.sv]
// ----------------------------------------------------------------------------
// GIF block stream parser package
// Types, marker bytes and helper functions shared by the parser modules.
// ----------------------------------------------------------------------------
package gbsp_pkg;

    localparam int unsigned DataW   = 8;
    localparam int unsigned FrameW  = 16;
    localparam int unsigned TableW  = 10;
    localparam int unsigned OutDataW = 24;

    localparam logic [7:0] MarkImage   = 8'h2C;
    localparam logic [7:0] MarkTrailer = 8'h3B;
    localparam logic [7:0] MarkExt     = 8'h21;
    localparam logic [2:0] SizeMask    = 3'h7;

    localparam logic [3:0] HeaderLastIdx = 4'd12;
    localparam logic [3:0] HeaderPackIdx = 4'd10;
    localparam logic [3:0] DescLastIdx   = 4'd8;

    typedef enum logic [3:0] {
        SEC_HEADER   = 4'd0,
        SEC_GCT      = 4'd1,
        SEC_INTRO    = 4'd2,
        SEC_LABEL    = 4'd3,
        SEC_SUB_LEN  = 4'd4,
        SEC_SUB_DATA = 4'd5,
        SEC_DESC     = 4'd6,
        SEC_LCT      = 4'd7,
        SEC_LZW      = 4'd8,
        SEC_TRAILER  = 4'd9,
        SEC_IGNORED  = 4'd10
    } section_t;

    typedef enum logic [10:0] {
        PH_HDR   = 11'b000_0000_0001,
        PH_GCT   = 11'b000_0000_0010,
        PH_INTRO = 11'b000_0000_0100,
        PH_LABEL = 11'b000_0000_1000,
        PH_XLEN  = 11'b000_0001_0000,
        PH_XDAT  = 11'b000_0010_0000,
        PH_DESC  = 11'b000_0100_0000,
        PH_LCT   = 11'b000_1000_0000,
        PH_LZW   = 11'b001_0000_0000,
        PH_ILEN  = 11'b010_0000_0000,
        PH_IDAT  = 11'b100_0000_0000
    } phase_t;

    typedef struct packed {
        logic              stream_done;
        logic [FrameW-1:0] frame_number;
        section_t          section;
        logic              keep_byte;
    } result_t;

    // A color table holds 3 << (size + 1) bytes when its flag bit is set.
    function automatic logic [TableW-1:0] table_len(input logic [7:0] pk);
        logic [TableW-1:0] base;
        logic [3:0]        sh;
        base = TableW'(3);
        sh   = {1'b0, pk[2:0] & SizeMask} + 4'd1;
        return pk[7] ? (base << sh) : '0;
    endfunction

endpackage

[rtl/core/gbsp_walker.sv]
// ----------------------------------------------------------------------------
// GIF block stream parser walker
// Holds the parse state and labels one stream byte per step.
// ----------------------------------------------------------------------------
module gbsp_walker
    import gbsp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step_en,
    input  logic [DataW-1:0] data_byte,
    output result_t          res
);

    phase_t            phase_reg, phase_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic [7:0]        remain_reg, remain_next;
    logic [TableW-1:0] tbl_reg, tbl_next;
    logic [FrameW-1:0] frame_reg, frame_next;
    logic              done_reg, done_next;
    logic [TableW-1:0] tbl_dec;
    logic [7:0]        remain_dec;

    assign tbl_dec    = (tbl_reg != '0) ? tbl_reg - TableW'(1) : tbl_reg;
    assign remain_dec = (remain_reg != '0) ? remain_reg - 8'd1 : remain_reg;

    always_comb begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        remain_next = remain_reg;
        tbl_next    = tbl_reg;
        frame_next  = frame_reg;
        done_next   = done_reg;

        res.keep_byte    = ~frame_reg[0];
        res.section      = SEC_INTRO;
        res.frame_number = frame_reg;
        res.stream_done  = done_reg;

        if (done_reg) begin
            res.keep_byte = 1'b0;
            res.section   = SEC_IGNORED;
        end else begin
            case (phase_reg)
                PH_HDR: begin
                    res.section   = SEC_HEADER;
                    res.keep_byte = 1'b1;
                    if (cnt_reg == HeaderPackIdx) begin
                        tbl_next = table_len(data_byte);
                    end
                    cnt_next = cnt_reg + 4'd1;
                    if (cnt_reg == HeaderLastIdx) begin
                        cnt_next   = '0;
                        phase_next = (tbl_reg != '0) ? PH_GCT : PH_INTRO;
                    end
                end
                PH_GCT: begin
                    res.section   = SEC_GCT;
                    res.keep_byte = 1'b1;
                    tbl_next      = tbl_dec;
                    if (tbl_dec == '0) begin
                        phase_next = PH_INTRO;
                    end
                end
                PH_LABEL: begin
                    res.section = SEC_LABEL;
                    phase_next  = PH_XLEN;
                end
                PH_XLEN, PH_ILEN: begin
                    res.section = SEC_SUB_LEN;
                    if (data_byte == 8'd0) begin
                        if (phase_reg == PH_ILEN && frame_reg != '1) begin
                            frame_next = frame_reg + FrameW'(1);
                        end
                        phase_next = PH_INTRO;
                    end else begin
                        remain_next = data_byte;
                        phase_next  = (phase_reg == PH_XLEN) ? PH_XDAT : PH_IDAT;
                    end
                end
                PH_XDAT, PH_IDAT: begin
                    res.section = SEC_SUB_DATA;
                    remain_next = remain_dec;
                    if (remain_dec == 8'd0) begin
                        phase_next = (phase_reg == PH_XDAT) ? PH_XLEN : PH_ILEN;
                    end
                end
                PH_DESC: begin
                    res.section = SEC_DESC;
                    cnt_next    = cnt_reg + 4'd1;
                    if (cnt_reg == DescLastIdx) begin
                        cnt_next   = '0;
                        tbl_next   = table_len(data_byte);
                        phase_next = (table_len(data_byte) != '0) ? PH_LCT : PH_LZW;
                    end
                end
                PH_LCT: begin
                    res.section = SEC_LCT;
                    tbl_next    = tbl_dec;
                    if (tbl_dec == '0) begin
                        phase_next = PH_LZW;
                    end
                end
                PH_LZW: begin
                    res.section = SEC_LZW;
                    phase_next  = PH_ILEN;
                end
                default: begin
                    if (data_byte == MarkExt) begin
                        phase_next = PH_LABEL;
                    end else if (data_byte == MarkImage) begin
                        cnt_next   = '0;
                        phase_next = PH_DESC;
                    end else if (data_byte == MarkTrailer) begin
                        res.section     = SEC_TRAILER;
                        done_next       = 1'b1;
                        res.stream_done = 1'b1;
                    end else begin
                        phase_next = PH_INTRO;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HDR;
            cnt_reg    <= '0;
            remain_reg <= '0;
            tbl_reg    <= '0;
            frame_reg  <= '0;
            done_reg   <= 1'b0;
        end else if (step_en) begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            remain_reg <= remain_next;
            tbl_reg    <= tbl_next;
            frame_reg  <= frame_next;
            done_reg   <= done_next;
        end
    end

endmodule

[rtl/core/gif_block_stream_parser.sv]
// ----------------------------------------------------------------------------
// GIF block stream parser
// Labels each byte of a GIF stream with its section, frame and keep flag.
// ----------------------------------------------------------------------------
// One request carries one file byte and yields one labeled result. The block
// takes a byte every cycle while the downstream side keeps up. A taken byte
// waits in the input register, and its result is offered once the state
// update moves it into the result register. The single state update per
// byte sets this rate. While a result waits for the downstream side, the
// input register takes one more byte, and the input then stalls until the
// waiting result is accepted.
module gif_block_stream_parser
    import gbsp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [DataW-1:0]    s_tdata,   // [7:0] data_byte
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OutDataW-1:0] m_tdata    // [0] keep_byte, [4:1] section,
                                           // [20:5] frame_number, [21] stream_done
);

`include "gif_block_stream_parser_defines.svh"

    logic             in_valid_reg;
    logic [DataW-1:0] in_byte_reg;
    logic             out_valid_reg;
    result_t          out_res_reg;
    result_t          step_res;
    logic             out_free;
    logic             advance;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;

    gbsp_walker u_walker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .data_byte (in_byte_reg),
        .res       (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (advance) begin
            out_res_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OutDataW - $bits(result_t)){1'b0}}, out_res_reg};

    `GBSP_ASSERT_SAME(a_ignored_done, aclk, aresetn, m_tvalid && out_res_reg.section == SEC_IGNORED, out_res_reg.stream_done, "Ignored byte without stream done")
    `GBSP_ASSERT_SAME(a_header_kept, aclk, aresetn, m_tvalid && (out_res_reg.section == SEC_HEADER || out_res_reg.section == SEC_GCT), out_res_reg.keep_byte, "Header byte dropped")
    `GBSP_ASSERT_NEXT(a_in_hold, aclk, aresetn, in_valid_reg && !advance, in_valid_reg && $stable(in_byte_reg), "Input register lost a stalled byte")

endmodule

[tb/sv/gbsp_tb_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// GIF block stream parser verification package
// Layout tracker that labels GIF bytes the way the parser should, and the
// scoreboard that holds predicted labels and compares them with results.
// ----------------------------------------------------------------------------
package gbsp_tb_pkg;
    import gbsp_pkg::*;

    localparam logic [7:0] ImageIntro   = 8'h2C;
    localparam logic [7:0] TrailerByte  = 8'h3B;
    localparam logic [7:0] ExtIntro     = 8'h21;
    localparam int         HdrBytes     = 13;
    localparam int         HdrPackedPos = 10;
    localparam int         DescBytes    = 9;

    class gif_layout_tracker;
        phase_t      phase;
        logic [9:0]  field_idx;
        logic [7:0]  sub_left;
        logic [9:0]  table_left;
        logic [15:0] frames;
        bit          done;

        function new();
            phase      = PH_HDR;
            field_idx  = '0;
            sub_left   = '0;
            table_left = '0;
            frames     = '0;
            done       = 1'b0;
        endfunction

        function logic [9:0] table_size(logic [7:0] pk_byte);
            int n;
            n = pk_byte[7] ? (3 << (int'(pk_byte[2:0]) + 1)) : 0;
            return n[9:0];
        endfunction

        function result_t advance(logic [7:0] b);
            result_t r;
            r.keep_byte    = ~frames[0];
            r.frame_number = frames;
            r.section      = SEC_INTRO;
            if (done) begin
                r.keep_byte   = 1'b0;
                r.section     = SEC_IGNORED;
                r.stream_done = 1'b1;
                return r;
            end
            case (phase)
                PH_HDR: begin
                    r.section   = SEC_HEADER;
                    r.keep_byte = 1'b1;
                    if (field_idx == HdrPackedPos) table_left = table_size(b);
                    if (field_idx == HdrBytes - 1) begin
                        field_idx = '0;
                        phase     = (table_left != 0) ? PH_GCT : PH_INTRO;
                    end else begin
                        field_idx = field_idx + 1'b1;
                    end
                end
                PH_GCT: begin
                    r.section   = SEC_GCT;
                    r.keep_byte = 1'b1;
                    if (table_left != 0) table_left = table_left - 1'b1;
                    if (table_left == 0) phase = PH_INTRO;
                end
                PH_LABEL: begin
                    r.section = SEC_LABEL;
                    phase     = PH_XLEN;
                end
                PH_XLEN, PH_ILEN: begin
                    r.section = SEC_SUB_LEN;
                    if (b == 8'h00) begin
                        if (phase == PH_ILEN && frames != 16'hFFFF) frames = frames + 1'b1;
                        phase = PH_INTRO;
                    end else begin
                        sub_left = b;
                        phase    = (phase == PH_XLEN) ? PH_XDAT : PH_IDAT;
                    end
                end
                PH_XDAT, PH_IDAT: begin
                    r.section = SEC_SUB_DATA;
                    if (sub_left != 0) sub_left = sub_left - 1'b1;
                    if (sub_left == 0) phase = (phase == PH_XDAT) ? PH_XLEN : PH_ILEN;
                end
                PH_DESC: begin
                    r.section = SEC_DESC;
                    if (field_idx == DescBytes - 1) begin
                        field_idx  = '0;
                        table_left = table_size(b);
                        phase      = (table_left != 0) ? PH_LCT : PH_LZW;
                    end else begin
                        field_idx = field_idx + 1'b1;
                    end
                end
                PH_LCT: begin
                    r.section = SEC_LCT;
                    if (table_left != 0) table_left = table_left - 1'b1;
                    if (table_left == 0) phase = PH_LZW;
                end
                PH_LZW: begin
                    r.section = SEC_LZW;
                    phase     = PH_ILEN;
                end
                default: begin
                    phase = PH_INTRO;
                    if (b == ExtIntro) begin
                        phase = PH_LABEL;
                    end else if (b == ImageIntro) begin
                        field_idx = '0;
                        phase     = PH_DESC;
                    end else if (b == TrailerByte) begin
                        r.section = SEC_TRAILER;
                        done      = 1'b1;
                    end
                end
            endcase
            r.stream_done = done;
            return r;
        endfunction
    endclass

    class byte_label_scoreboard;
        gif_layout_tracker walker;
        result_t           pending_labels[$];
        int                mismatches;
        int                labels_checked;

        function new();
            walker         = new();
            mismatches     = 0;
            labels_checked = 0;
        endfunction

        function void note_byte(logic [7:0] b);
            pending_labels.push_back(walker.advance(b));
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= 40) $display("%0t: mismatch: %s", $time, what);
        endtask

        task check_label(logic [OutDataW-1:0] tdata);
            result_t got;
            result_t want;
            got = result_t'(tdata[$bits(result_t)-1:0]);
            if (pending_labels.size() == 0) begin
                report($sformatf("result %h arrived with no request outstanding", tdata));
                return;
            end
            want = pending_labels.pop_front();
            labels_checked++;
            if (tdata[OutDataW-1:$bits(result_t)] != '0)
                report($sformatf("request %0d padding bits set: %h", labels_checked, tdata));
            if (got.keep_byte !== want.keep_byte)
                report($sformatf("request %0d keep_byte %b, want %b",
                                 labels_checked, got.keep_byte, want.keep_byte));
            if (got.section !== want.section)
                report($sformatf("request %0d section %0d, want %0d",
                                 labels_checked, got.section, want.section));
            if (got.frame_number !== want.frame_number)
                report($sformatf("request %0d frame_number %0d, want %0d",
                                 labels_checked, got.frame_number, want.frame_number));
            if (got.stream_done !== want.stream_done)
                report($sformatf("request %0d stream_done %b, want %b",
                                 labels_checked, got.stream_done, want.stream_done));
        endtask
    endclass

endpackage

[tb/sv/tb_gif_block_stream_parser.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// GIF block stream parser testbench
// Feeds one long GIF stream through the parser: a directed opening, random
// extensions, frames and noise, a run of minimal frames sent back to back,
// more random blocks, then the trailer and ignored bytes. Every result is
// checked against a predicted label, with random idling on both stream sides.
// ----------------------------------------------------------------------------
module tb_gif_block_stream_parser;
    import gbsp_pkg::*;
    import gbsp_tb_pkg::*;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [DataW-1:0]    s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [OutDataW-1:0] m_tdata;

    bit                   no_idle;
    bit                   trailer_open;
    int                   bytes_sent;
    byte_label_scoreboard labels;
    gif_layout_tracker    shadow_layout;

    logic [7:0] opening_bytes[$] = '{
        8'h47, 8'h49, 8'h46, 8'h38, 8'h39, 8'h61, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h80, 8'hFF,
        8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00,
        8'h21, 8'hF9, 8'h04, 8'h80, 8'h7F, 8'h00, 8'hFF, 8'h00, 8'h21, 8'hFE, 8'h00,
        8'h2C, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80,
        8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h08, 8'h01, 8'hFF, 8'h00,
        8'h2C, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h7F, 8'h02, 8'h00
    };

    gif_block_stream_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    initial begin
        #40_000_000;
        $display("gif_block_stream_parser regression: fail");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) labels.check_label(m_tdata);
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        labels.note_byte(b);
        bytes_sent++;
        @(negedge aclk);
    endtask

    // A trailer marker is only let through at a block intro once the stream
    // is meant to end, so noise cannot close the stream early.
    task automatic emit(input logic [7:0] b);
        logic [7:0] v;
        v = b;
        if (!trailer_open && !shadow_layout.done && shadow_layout.phase == PH_INTRO &&
            v == TrailerByte) begin
            v = 8'h3A;
        end
        void'(shadow_layout.advance(v));
        send_byte(v);
    endtask

    task automatic emit_chain(input int blocks);
        int len;
        repeat (blocks) begin
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 8);
            emit(8'(len));
            repeat (len) emit(8'($urandom));
        end
        emit(8'h00);
    endtask

    task automatic emit_image(input bit minimal);
        logic [7:0] pk;
        emit(ImageIntro);
        repeat (DescBytes - 1) emit(8'($urandom));
        pk = 8'($urandom);
        if (minimal || $urandom_range(0, 2) == 0) begin
            pk[7] = 1'b0;
        end else if ($urandom_range(0, 39) != 0) begin
            pk[2:0] = 3'($urandom_range(0, 2));
        end
        emit(pk);
        while (shadow_layout.phase == PH_LCT) emit(8'($urandom));
        emit(8'($urandom));
        emit_chain(minimal ? 0 : $urandom_range(0, 3));
    endtask

    task automatic emit_block();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 12) begin
            emit_image(1'b0);
        end else if (pick < 17) begin
            emit(ExtIntro);
            emit(8'($urandom));
            emit_chain($urandom_range(0, 3));
        end else if (pick == 17) begin
            emit(8'($urandom));
        end else if (pick == 18) begin
            emit($urandom_range(0, 1) ? ImageIntro : ExtIntro);
            repeat ($urandom_range(1, 6)) emit(8'($urandom));
        end else begin
            repeat ($urandom_range(1, 6)) emit(8'($urandom));
        end
    endtask

    task automatic realign();
        while (shadow_layout.phase != PH_INTRO) emit(8'h00);
    endtask

    initial begin : downstream
        int gap;
        bit held;
        m_tready = 1'b0;
        held     = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 4);
            if (!held && labels.labels_checked >= 600) begin
                gap  = 400;
                held = 1'b1;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        no_idle       = 1'b0;
        trailer_open  = 1'b0;
        bytes_sent    = 0;
        labels        = new();
        shadow_layout = new();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (opening_bytes[i]) emit(opening_bytes[i]);
        while (bytes_sent < 1200) emit_block();
        realign();

        no_idle = 1'b1;
        repeat (20) emit_image(1'b1);
        no_idle = 1'b0;
        repeat (12) emit_block();
        realign();

        trailer_open = 1'b1;
        emit(TrailerByte);
        repeat (20) emit(8'($urandom));
        s_tvalid <= 1'b0;

        while (labels.pending_labels.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (labels.mismatches == 0) begin
            $display("gif_block_stream_parser regression: pass");
        end else begin
            $display("gif_block_stream_parser regression: fail");
        end
        $finish;
    end

endmodule
